### hdl/cbe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_pkg - shared types and constants of the character bar graph encoder
// Field widths, register selection and character codes used by every file but the queue.
// ----------------------------------------------------------------------------
package cbe_pkg;

	// Field widths fixed by the interface.
	localparam int PROG_W     = 16;
	localparam int MAX_W      = 16;
	localparam int LEN_W      = 6;
	localparam int CODE_W     = 3;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Registers sit on a 4-byte stride; address bit 2 picks the register.
	localparam int REG_SEL_BIT = 2;

	typedef enum logic {
		REG_MAX_PROGRESS = 1'b0,
		REG_BAR_LENGTH   = 1'b1
	} reg_sel_t;

	// Reset values of the configuration registers.
	localparam logic [MAX_W-1:0] MAX_PROGRESS_RST = 16'hFFFF;
	localparam logic [LEN_W-1:0] BAR_LENGTH_RST   = 6'd16;

	// Code of a cell that holds no lit pixel.
	localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd1;

endpackage : cbe_pkg
`default_nettype wire

### hdl/cbe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_front - input side: clamp, scale and divide
// Accepts progress values, forms progress * cells * pixels and divides it by
// the full scale value one quotient bit per cycle, holding at the last bit
// while the previous result waits on a full queue, then hands the pixel fill
// and the cell count to the queue.
module cbe_front
	import cbe_pkg::*;
#(
	parameter int PIXELS_PER_CHAR = 5,
	parameter int MAX_CELLS       = 40,
	localparam int CELL_W = $clog2(MAX_CELLS + 1),
	localparam int FILL_W = $clog2(MAX_CELLS * PIXELS_PER_CHAR + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [PROG_W-1:0] progress,
	input  wire logic [MAX_W-1:0]  max_progress,
	input  wire logic [LEN_W-1:0]  bar_length,
	output logic                   q_push,
	input  wire logic              q_full,
	output logic [FILL_W-1:0]      q_fill,
	output logic [CELL_W-1:0]      q_cells
);

	localparam int NUM_W  = PROG_W + FILL_W;
	localparam int STEP_W = (FILL_W > 1) ? $clog2(FILL_W) : 1;
	localparam int LENX_W = LEN_W + 1;

	// Stage 1: clamped operands.
	logic              valid_s1;
	logic [PROG_W-1:0] prog_s1;
	logic [FILL_W-1:0] cpx_s1;
	logic [CELL_W-1:0] cells_s1;
	logic              zmax_s1;
	// Stage 2: product.
	logic              valid_s2;
	logic [NUM_W-1:0]  num_s2;
	logic [FILL_W-1:0] cpx_s2;
	logic [CELL_W-1:0] cells_s2;
	logic              zmax_s2;
	// Divider.
	logic              div_busy_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  den_q;
	logic [FILL_W-1:0] quo_q;
	logic [FILL_W-1:0] cpx_q;
	logic [CELL_W-1:0] cells_q;
	logic              zmax_q;
	// Result waiting for the queue.
	logic              res_valid_q;
	logic [FILL_W-1:0] res_fill_q;
	logic [CELL_W-1:0] res_cells_q;

	logic              accept;
	logic [CELL_W-1:0] cells_cfg;
	logic [PROG_W-1:0] prog_clamp;
	logic              res_free;
	logic              div_last;
	logic              div_fin;
	logic              div_take;
	logic              mv_s2;
	logic              mv_s1;
	logic              qbit;
	logic [FILL_W-1:0] quo_next;

	always_comb begin
		if ({1'b0, bar_length} > LENX_W'(MAX_CELLS)) begin
			cells_cfg = CELL_W'(MAX_CELLS);
		end else begin
			cells_cfg = CELL_W'(bar_length);
		end
		prog_clamp = (progress > max_progress) ? max_progress : progress;
	end

	assign q_push   = res_valid_q && !q_full;
	assign res_free = !res_valid_q || !q_full;
	assign div_last = div_busy_q && (step_q == '0);
	assign div_fin  = div_last && res_free;
	assign div_take = !div_busy_q || div_fin;
	assign mv_s2    = valid_s2 && div_take;
	assign mv_s1    = valid_s1 && (!valid_s2 || mv_s2);
	assign full     = valid_s1 && !mv_s1;
	assign accept   = push && !full;

	assign qbit     = (rem_q >= den_q);
	assign quo_next = {quo_q[FILL_W-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			div_busy_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// A bar of no cells yields no transaction at all.
			if (accept && (cells_cfg != '0)) begin
				valid_s1 <= 1'b1;
			end else if (mv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (mv_s1) begin
				valid_s2 <= 1'b1;
			end else if (mv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (mv_s2) begin
				div_busy_q <= 1'b1;
			end else if (div_fin) begin
				div_busy_q <= 1'b0;
			end
			if (div_fin) begin
				res_valid_q <= 1'b1;
			end else if (q_push) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prog_s1  <= prog_clamp;
			cells_s1 <= cells_cfg;
			cpx_s1   <= FILL_W'(cells_cfg * PIXELS_PER_CHAR);
			zmax_s1  <= (max_progress == '0);
		end
		if (mv_s1) begin
			num_s2   <= {{FILL_W{1'b0}}, prog_s1} * {{PROG_W{1'b0}}, cpx_s1};
			cpx_s2   <= cpx_s1;
			cells_s2 <= cells_s1;
			zmax_s2  <= zmax_s1;
		end
		if (mv_s2) begin
			rem_q   <= num_s2;
			den_q   <= {{FILL_W{1'b0}}, max_progress} << (FILL_W - 1);
			quo_q   <= '0;
			step_q  <= STEP_W'(FILL_W - 1);
			cpx_q   <= cpx_s2;
			cells_q <= cells_s2;
			zmax_q  <= zmax_s2;
		end else if (div_busy_q && (!div_last || res_free)) begin
			if (qbit) begin
				rem_q <= rem_q - den_q;
			end
			den_q  <= den_q >> 1;
			quo_q  <= quo_next;
			step_q <= step_q - STEP_W'(1);
		end
		if (div_fin) begin
			// A zero full scale shows the bar full.
			res_fill_q  <= zmax_q ? cpx_q : quo_next;
			res_cells_q <= cells_q;
		end
	end

	assign q_fill  = res_fill_q;
	assign q_cells = res_cells_q;

endmodule : cbe_front
`default_nettype wire

### hdl/cbe_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_queue - short first-in first-out queue between front and back
// Holds scaled bars so that the divider and the cell emitter stall apart.
// ----------------------------------------------------------------------------
module cbe_queue #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  q_full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule : cbe_queue
`default_nettype wire

### hdl/cbe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_back - cell emitter
// Walks the cells of one bar and drives the output register, one cell per cycle while it is free or popped.
// ----------------------------------------------------------------------------
module cbe_back
	import cbe_pkg::*;
#(
	parameter int PIXELS_PER_CHAR = 5,
	parameter int MAX_CELLS       = 40,
	localparam int CELL_W = $clog2(MAX_CELLS + 1),
	localparam int FILL_W = $clog2(MAX_CELLS * PIXELS_PER_CHAR + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire logic [FILL_W-1:0] q_fill,
	input  wire logic [CELL_W-1:0] q_cells,
	output logic                   q_pop,
	output logic                   empty,
	input  wire logic              pop,
	output logic [CODE_W-1:0]      char_code,
	output logic                   last_cell
);

	localparam logic [CODE_W-1:0] CODE_FULL = CODE_W'(PIXELS_PER_CHAR + 1);
	localparam int EXT_W = FILL_W + 1;

	logic              act_q;
	logic [FILL_W-1:0] fill_q;
	logic [CELL_W-1:0] cells_q;
	logic [CELL_W-1:0] idx_q;
	logic [FILL_W-1:0] start_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic              last_q;

	logic              emit;
	logic              is_last;
	logic [EXT_W-1:0]  end_px;
	logic [CODE_W-1:0] code;

	assign emit    = act_q && (!out_valid_q || pop);
	assign is_last = (idx_q == (cells_q - CELL_W'(1)));
	assign q_pop   = !q_empty && (!act_q || (emit && is_last));
	assign end_px  = EXT_W'(start_q) + EXT_W'(PIXELS_PER_CHAR);

	// Inside a partial cell the fill lies in [start, start + pixels), so
	// the remainder is simply fill minus start.
	always_comb begin
		if (end_px > EXT_W'(fill_q)) begin
			if (start_q > fill_q) begin
				code = CODE_EMPTY;
			end else begin
				code = CODE_W'(fill_q - start_q) + CODE_W'(1);
			end
		end else begin
			code = CODE_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				act_q <= 1'b1;
			end else if (emit && is_last) begin
				act_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			fill_q  <= q_fill;
			cells_q <= q_cells;
			idx_q   <= '0;
			start_q <= '0;
		end else if (emit) begin
			idx_q   <= idx_q + CELL_W'(1);
			start_q <= start_q + FILL_W'(PIXELS_PER_CHAR);
		end
		if (emit) begin
			code_q <= code;
			last_q <= is_last;
		end
	end

	assign empty     = !out_valid_q;
	assign char_code = code_q;
	assign last_cell = last_q;

endmodule : cbe_back
`default_nettype wire

### hdl/character_bargraph_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// character_bargraph_encoder - progress value to character cell bar encoder
// Turns one progress value into a row of custom character codes for a text
// display bar, one code per cell, left to right, the final cell marked.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   input     in         push / full            progress
//   result    out        empty / pop            char_code, last_cell
//   config    in         APB (psel, penable)    max_progress @0x0, bar_length @0x4
//
// Cells leave the block one per cycle while pop stays high. The front end
// divides in a restoring divider, which produces one quotient bit per cycle
// while its result can move on, FILL_W quotient bits per transaction (FILL_W =
// bits of MAX_CELLS * PIXELS_PER_CHAR, 8 at the defaults). It takes new
// transactions into its clamp and product stages while the divider works.
// Reset is asynchronous and clears all control state; no clearing pass runs.
// A stall on pop holds the output register, backs up the two-entry queue and
// finally raises full; the input side keeps working until then.
// ----------------------------------------------------------------------------
module character_bargraph_encoder
	import cbe_pkg::*;
#(
	parameter int PIXELS_PER_CHAR = 5,
	parameter int MAX_CELLS       = 40
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	// Input queue side
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [PROG_W-1:0]     progress,
	// Result queue side
	output logic                       empty,
	input  wire logic                  pop,
	output logic [CODE_W-1:0]          char_code,
	output logic                       last_cell
);

	localparam int CELL_W = $clog2(MAX_CELLS + 1);
	localparam int FILL_W = $clog2(MAX_CELLS * PIXELS_PER_CHAR + 1);
	localparam int ENT_W  = FILL_W + CELL_W;

	logic [MAX_W-1:0] max_progress_q;
	logic [LEN_W-1:0] bar_length_q;
	logic             cfg_wr;
	reg_sel_t         cfg_sel;

	// Front to queue.
	logic              fq_push;
	logic              fq_full;
	logic [FILL_W-1:0] fq_fill;
	logic [CELL_W-1:0] fq_cells;
	// Queue to back.
	logic              bq_pop;
	logic              bq_empty;
	logic [ENT_W-1:0]  bq_data;

	// ------------------------------------------------------------------
	// Configuration registers. The port never inserts wait states, and
	// the register is picked by address bit 2 alone; the lower address
	// bits are byte offsets within the register.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = reg_sel_t'(paddr[REG_SEL_BIT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_progress_q <= MAX_PROGRESS_RST;
			bar_length_q   <= BAR_LENGTH_RST;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_MAX_PROGRESS: max_progress_q <= pwdata[MAX_W-1:0];
				REG_BAR_LENGTH:   bar_length_q   <= pwdata[LEN_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_MAX_PROGRESS: prdata = {{(APB_DATA_W-MAX_W){1'b0}}, max_progress_q};
			REG_BAR_LENGTH:   prdata = {{(APB_DATA_W-LEN_W){1'b0}}, bar_length_q};
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Front end: takes a transaction, clamps it, multiplies and divides
	// to get the pixel fill of the whole bar.
	// ------------------------------------------------------------------
	cbe_front #(
		.PIXELS_PER_CHAR (PIXELS_PER_CHAR),
		.MAX_CELLS       (MAX_CELLS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.progress     (progress),
		.max_progress (max_progress_q),
		.bar_length   (bar_length_q),
		.q_push       (fq_push),
		.q_full       (fq_full),
		.q_fill       (fq_fill),
		.q_cells      (fq_cells)
	);

	// ------------------------------------------------------------------
	// Two-entry queue of scaled bars, fill in the upper bits.
	// ------------------------------------------------------------------
	cbe_queue #(
		.WIDTH (ENT_W),
		.DEPTH (2)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data ({fq_fill, fq_cells}),
		.q_full  (fq_full),
		.rd_en   (bq_pop),
		.rd_data (bq_data),
		.q_empty (bq_empty)
	);

	// ------------------------------------------------------------------
	// Back end: one cell per cycle into the output register while it is free or popped.
	// ------------------------------------------------------------------
	cbe_back #(
		.PIXELS_PER_CHAR (PIXELS_PER_CHAR),
		.MAX_CELLS       (MAX_CELLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (bq_empty),
		.q_fill    (bq_data[ENT_W-1:CELL_W]),
		.q_cells   (bq_data[CELL_W-1:0]),
		.q_pop     (bq_pop),
		.empty     (empty),
		.pop       (pop),
		.char_code (char_code),
		.last_cell (last_cell)
	);

endmodule : character_bargraph_encoder
`default_nettype wire

### hdl/cbe_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_checker - port-level assertions for the bar graph encoder
// Watches the top level's ports and flags behavior the encoder never shows.
// ----------------------------------------------------------------------------
module cbe_checker
	import cbe_pkg::*;
#(
	parameter int PIXELS_PER_CHAR = 5
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  psel,
	input wire logic                  penable,
	input wire logic                  pwrite,
	input wire logic [APB_ADDR_W-1:0] paddr,
	input wire logic [APB_DATA_W-1:0] pwdata,
	input wire logic [APB_DATA_W-1:0] prdata,
	input wire logic                  pready,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire logic [CODE_W-1:0]     char_code,
	input wire logic                  last_cell
);

	// Codes stay within 1..pixels+1 only while the full code fits 3 bits.
	localparam bit NO_WRAP = (PIXELS_PER_CHAR <= 6);
	localparam logic [CODE_W-1:0] CODE_TOP = CODE_W'(PIXELS_PER_CHAR + 1);

	// The result side is empty while reset is applied.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// A waiting result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(char_code) && $stable(last_cell)))
		else $error("waiting result changed");

	// The cells of one bar follow each other with no gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_cell) |=> !empty)
		else $error("gap inside a bar");

	// Once a cell is empty, every later cell of the same bar is empty too.
	a_empty_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(NO_WRAP && !empty && pop && !last_cell && (char_code == CODE_EMPTY))
		|=> (char_code == CODE_EMPTY))
		else $error("lit cell after an empty cell");

	// A full scale value written is read back on the next cycle.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && !paddr[REG_SEL_BIT])
		##1 (psel && !pwrite && !paddr[REG_SEL_BIT] && NO_WRAP
			&& (char_code <= CODE_TOP || empty))
		|-> (prdata[MAX_W-1:0] == $past(pwdata[MAX_W-1:0])))
		else $error("full scale read back wrong");

endmodule : cbe_checker

bind character_bargraph_encoder cbe_checker #(
	.PIXELS_PER_CHAR (PIXELS_PER_CHAR)
) u_cbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready),
	.empty     (empty),
	.pop       (pop),
	.char_code (char_code),
	.last_cell (last_cell)
);
`default_nettype wire
